// ----- rtl/ptpbmc_pkg.sv -----
// Shared types, constants and helpers for the best-master-clock role machine.
package ptpbmc_pkg;

    localparam int IDENTITY_BYTES = 8;
    localparam int ID_W           = 8 * IDENTITY_BYTES;
    localparam int CNT_W          = 16;
    localparam int LIMIT_W        = 16;
    localparam int CMP_W          = (CNT_W + 1 > LIMIT_W) ? CNT_W + 1 : LIMIT_W;
    localparam int REST_W         = 64;
    localparam int KEY_W          = REST_W + 8 + ID_W;

    localparam int IN_DATA_W      = 72 + ID_W;
    localparam int OUT_PAYLOAD_W  = 21 + ID_W;
    localparam int OUT_DATA_W     = ((OUT_PAYLOAD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W      = OUT_DATA_W - OUT_PAYLOAD_W;
    localparam int CMD_W          = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENABLE   = 2'd0,
        CMD_ANNOUNCE = 2'd1,
        CMD_TICK     = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT  = 3'b001,
        ST_GM    = 3'b010,
        ST_SLAVE = 3'b100
    } state_t;

    localparam logic [1:0] ROLE_INIT  = 2'd0;
    localparam logic [1:0] ROLE_GM    = 2'd1;
    localparam logic [1:0] ROLE_SLAVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ANNOUNCE_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANNOUNCE_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_PRIO1         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_CLOCK_QUALITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_PRIO2         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_STEPS_REMOVED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_CLOCK_SOURCE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IDENTITY      = 3'd7;

    typedef struct packed {
        logic [LIMIT_W-1:0] announce_interval;
        logic [LIMIT_W-1:0] announce_timeout;
        logic [7:0]         own_prio1;
        logic [31:0]        own_clock_quality;
        logic [7:0]         own_prio2;
        logic [15:0]        own_steps_removed;
        logic [7:0]         own_clock_source;
        logic [ID_W-1:0]    own_identity;
    } cfg_t;

    typedef struct packed {
        cmd_t            cmd;
        logic            better;
        logic [ID_W-1:0] rx_id;
    } qentry_t;

    // first member lands in the top bits, so role sits at bit 0
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [ID_W-1:0]      gm_identity;
        logic                 better_found;
        logic [15:0]          announce_seq;
        logic                 send_announce;
        logic                 sync_master;
        logic [1:0]           role;
    } out_word_t;

    typedef struct packed {
        logic             fire;
        logic [CNT_W-1:0] cnt;
    } tick_t;

    function automatic tick_t count_tick(logic [CNT_W-1:0] cnt, logic [LIMIT_W-1:0] limit);
        logic [CNT_W:0] nxt;
        tick_t          r;
        nxt    = {1'b0, cnt} + (CNT_W + 1)'(1);
        r.fire = CMP_W'(nxt) >= CMP_W'(limit);
        if (r.fire)
            r.cnt = '0;
        else if (nxt[CNT_W])
            r.cnt = '1;
        else
            r.cnt = nxt[CNT_W-1:0];
        return r;
    endfunction

    function automatic logic [1:0] role_code(state_t st);
        logic [1:0] r;
        unique case (st)
            ST_GM:    r = ROLE_GM;
            ST_SLAVE: r = ROLE_SLAVE;
            default:  r = ROLE_INIT;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/ptp_best_master_clock_fsm_top.sv -----
// An accepted word passes through the queue and the back end's single output register.
// Throughput: one word per cycle while m_tready is high; that register paces the queue.
// The two-entry queue keeps s_tready high while m_tready stalls for up to two words.
// Reset: role init, counters, sequence and grandmaster identity zero, queue empty,
// configuration registers back to their defaults. No clearing pass.
module ptp_best_master_clock_fsm_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ptpbmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptpbmc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cmd[1:0]
    input  logic [ptpbmc_pkg::CMD_W-1:0]        s_tuser,
    // rx_prio1[7:0] rx_clock_class[15:8] rx_clock_accuracy[23:16]
    // rx_offset_variance[39:24] rx_prio2[47:40] rx_steps_removed[63:48]
    // rx_clock_source[71:64] rx_identity[135:72]
    input  logic [ptpbmc_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // role[1:0] sync_master[2] send_announce[3] announce_seq[19:4]
    // better_found[20] gm_identity[84:21] zero[87:85]
    output logic [ptpbmc_pkg::OUT_DATA_W-1:0]   m_tdata
);

    ptpbmc_pkg::cfg_t    cfg;
    ptpbmc_pkg::qentry_t front_entry;
    ptpbmc_pkg::qentry_t q_head;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    logic                q_push;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    ptpbmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ptpbmc_front u_front (
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .cfg     (cfg),
        .entry   (front_entry)
    );

    ptpbmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    ptpbmc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/ptpbmc_cfg.sv -----
// Configuration register file with reset defaults.
module ptpbmc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ptpbmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptpbmc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output ptpbmc_pkg::cfg_t                    cfg
);

    ptpbmc_pkg::cfg_t cfg_reg;
    ptpbmc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ptpbmc_pkg::REG_ANNOUNCE_INTERVAL:
                    cfg_next.announce_interval = cfg_wdata[ptpbmc_pkg::LIMIT_W-1:0];
                ptpbmc_pkg::REG_ANNOUNCE_TIMEOUT:
                    cfg_next.announce_timeout = cfg_wdata[ptpbmc_pkg::LIMIT_W-1:0];
                ptpbmc_pkg::REG_OWN_PRIO1:
                    cfg_next.own_prio1 = cfg_wdata[7:0];
                ptpbmc_pkg::REG_OWN_CLOCK_QUALITY:
                    cfg_next.own_clock_quality = cfg_wdata[31:0];
                ptpbmc_pkg::REG_OWN_PRIO2:
                    cfg_next.own_prio2 = cfg_wdata[7:0];
                ptpbmc_pkg::REG_OWN_STEPS_REMOVED:
                    cfg_next.own_steps_removed = cfg_wdata[15:0];
                ptpbmc_pkg::REG_OWN_CLOCK_SOURCE:
                    cfg_next.own_clock_source = cfg_wdata[7:0];
                ptpbmc_pkg::REG_OWN_IDENTITY:
                    cfg_next.own_identity = cfg_wdata[ptpbmc_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.announce_interval <= ptpbmc_pkg::LIMIT_W'(1000);
            cfg_reg.announce_timeout  <= ptpbmc_pkg::LIMIT_W'(3000);
            cfg_reg.own_prio1         <= 8'd248;
            cfg_reg.own_clock_quality <= 32'hF8FE_4100;
            cfg_reg.own_prio2         <= 8'd248;
            cfg_reg.own_steps_removed <= 16'd0;
            cfg_reg.own_clock_source  <= 8'd160;
            cfg_reg.own_identity      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/ptpbmc_front.sv -----
// Front end: decodes the input word and ranks the received vector against the own one.
module ptpbmc_front (
    input  logic [ptpbmc_pkg::CMD_W-1:0]      s_tuser,
    input  logic [ptpbmc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  ptpbmc_pkg::cfg_t                  cfg,
    output ptpbmc_pkg::qentry_t               entry
);

    logic [ptpbmc_pkg::KEY_W-1:0] rx_key;
    logic [ptpbmc_pkg::KEY_W-1:0] own_key;

    // key order: prio1, class, accuracy, variance, prio2, steps, source, identity
    assign rx_key  = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[39:24],
                      s_tdata[47:40], s_tdata[63:48], s_tdata[71:64],
                      s_tdata[72 +: ptpbmc_pkg::ID_W]};
    assign own_key = {cfg.own_prio1, cfg.own_clock_quality, cfg.own_prio2,
                      cfg.own_steps_removed, cfg.own_clock_source, cfg.own_identity};

    assign entry.cmd    = ptpbmc_pkg::cmd_t'(s_tuser);
    assign entry.better = rx_key < own_key;
    assign entry.rx_id  = s_tdata[72 +: ptpbmc_pkg::ID_W];

endmodule

// ----- rtl/ptpbmc_queue.sv -----
// Two-entry queue between the front end and the role machine.
module ptpbmc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ptpbmc_pkg::qentry_t  push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output ptpbmc_pkg::qentry_t  head
);

    ptpbmc_pkg::qentry_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign head  = mem[rd_ptr_reg];

endmodule

// ----- rtl/ptpbmc_back.sv -----
// Back end: role state machine, tick counters and the output register.
module ptpbmc_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ptpbmc_pkg::cfg_t                     cfg,
    input  logic                                 q_valid,
    input  ptpbmc_pkg::qentry_t                  q_head,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ptpbmc_pkg::OUT_DATA_W-1:0]    m_tdata
);

    ptpbmc_pkg::state_t                 state_reg;
    ptpbmc_pkg::state_t                 state_next;
    logic [ptpbmc_pkg::CNT_W-1:0]       repeat_reg;
    logic [ptpbmc_pkg::CNT_W-1:0]       repeat_next;
    logic [ptpbmc_pkg::CNT_W-1:0]       timeout_reg;
    logic [ptpbmc_pkg::CNT_W-1:0]       timeout_next;
    logic [15:0]                        seq_reg;
    logic [15:0]                        seq_next;
    logic [ptpbmc_pkg::ID_W-1:0]        gm_id_reg;
    logic [ptpbmc_pkg::ID_W-1:0]        gm_id_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    ptpbmc_pkg::out_word_t              out_word_reg;
    ptpbmc_pkg::out_word_t              out_word_next;
    ptpbmc_pkg::tick_t                  tick;
    logic                               send;
    logic [15:0]                        seq_out;
    logic                               better_out;

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next   = state_reg;
        repeat_next  = repeat_reg;
        timeout_next = timeout_reg;
        seq_next     = seq_reg;
        gm_id_next   = gm_id_reg;
        send         = 1'b0;
        seq_out      = 16'd0;
        better_out   = 1'b0;
        tick         = '0;
        if (q_pop)
        begin
            unique case (q_head.cmd)
                ptpbmc_pkg::CMD_ENABLE:
                begin
                    if (state_reg == ptpbmc_pkg::ST_INIT)
                    begin
                        gm_id_next  = cfg.own_identity;
                        state_next  = ptpbmc_pkg::ST_GM;
                        repeat_next = '0;
                    end
                end
                ptpbmc_pkg::CMD_ANNOUNCE:
                begin
                    if (state_reg != ptpbmc_pkg::ST_INIT)
                    begin
                        if (q_head.better)
                        begin
                            gm_id_next   = q_head.rx_id;
                            better_out   = 1'b1;
                            timeout_next = '0;
                            state_next   = ptpbmc_pkg::ST_SLAVE;
                        end
                        else
                        begin
                            gm_id_next = cfg.own_identity;
                        end
                    end
                end
                ptpbmc_pkg::CMD_TICK:
                begin
                    if (state_reg == ptpbmc_pkg::ST_GM)
                    begin
                        tick        = ptpbmc_pkg::count_tick(repeat_reg, cfg.announce_interval);
                        repeat_next = tick.cnt;
                        if (tick.fire)
                        begin
                            send     = 1'b1;
                            seq_out  = seq_reg;
                            seq_next = seq_reg + 16'd1;
                        end
                    end
                    else if (state_reg == ptpbmc_pkg::ST_SLAVE)
                    begin
                        tick         = ptpbmc_pkg::count_tick(timeout_reg, cfg.announce_timeout);
                        timeout_next = tick.cnt;
                        if (tick.fire)
                        begin
                            state_next  = ptpbmc_pkg::ST_GM;
                            repeat_next = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_word_next               = out_word_reg;
        out_valid_next              = out_valid_reg && !m_tready;
        if (q_pop)
        begin
            out_valid_next              = 1'b1;
            out_word_next.pad           = '0;
            out_word_next.gm_identity   = gm_id_next;
            out_word_next.better_found  = better_out;
            out_word_next.announce_seq  = seq_out;
            out_word_next.send_announce = send;
            out_word_next.sync_master   = state_next == ptpbmc_pkg::ST_GM;
            out_word_next.role          = ptpbmc_pkg::role_code(state_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptpbmc_pkg::ST_INIT;
            repeat_reg    <= '0;
            timeout_reg   <= '0;
            seq_reg       <= 16'd0;
            gm_id_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            repeat_reg    <= repeat_next;
            timeout_reg   <= timeout_next;
            seq_reg       <= seq_next;
            gm_id_reg     <= gm_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;

endmodule

// ----- rtl/ptpbmc_checker.sv -----
// Port-level checks on the output word stream, bound to the top level.
module ptpbmc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [ptpbmc_pkg::OUT_DATA_W-1:0]   m_tdata
);

    ptpbmc_pkg::out_word_t w;
    assign w = m_tdata;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_sync_role: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> w.sync_master == (w.role == ptpbmc_pkg::ROLE_GM))
        else $error("sync_master disagrees with role");

    a_send_gm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && w.send_announce |-> w.role == ptpbmc_pkg::ROLE_GM && !w.better_found)
        else $error("announce requested outside grandmaster");

    a_better_slave: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && w.better_found |-> w.role == ptpbmc_pkg::ROLE_SLAVE
            && w.announce_seq == 16'd0)
        else $error("better announce without slave role");

endmodule

bind ptp_best_master_clock_fsm_top ptpbmc_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
